// File: sv/u2a_pkg.sv
// ----------------------------------------------------------------------------
// u2a_pkg
// Constants and the digit-to-character mapping for the radix converter.
// ----------------------------------------------------------------------------
`default_nettype none

package u2a_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = 7;
    localparam int ADDR_W      = 6;
    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 7;
    localparam int CHUNK_W     = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] TEN       = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0]  CHAR_A    = 7'd97;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {1'b0, d};
        if (d >= TEN) begin
            return dx - {1'b0, TEN} + CHAR_A;
        end
        return dx + CHAR_ZERO;
    endfunction

endpackage

`default_nettype wire

// File: sv/unsigned_to_ascii_radix.sv
// ----------------------------------------------------------------------------
// unsigned_to_ascii_radix
// Converts an unsigned number into its ASCII digits in a radix of 2 to 36.
// ----------------------------------------------------------------------------
// A word on the slave side carries the value and the radix; the master side
// returns one word per digit, most significant digit first, with tlast on
// the final digit. A zero value gives the single digit '0'. Radix values
// below 2 are taken as 2 and values above 36 as 36.
// The value is divided repeatedly by the radix with a long-division unit that
// retires 8 dividend bits per cycle, passing over every chunk of the value
// for each digit. Remainders are pushed onto a 64-entry digit memory and
// popped back out; each pop goes through address, registered read and output.
// The block takes one word at a time: s_tready is high only while it is
// idle. Reset returns the block to idle and drops m_tvalid; the digit
// memory is not cleared, since every entry is written before it is read.
// When the receiver stalls, the current digit is held on m_tdata until it
// is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module unsigned_to_ascii_radix
    import u2a_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,  // value [63:0], radix [69:64]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,  // digit_char [6:0]
    output logic             m_tlast   // last_digit
);

    localparam int STEPS  = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD_W  = STEPS * CHUNK_W;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_LD,
        ST_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [PAD_W-1:0]     work_reg, work_next;
    logic [RADIX_W-1:0]   rem_reg, rem_next;
    logic [RADIX_W-1:0]   radix_reg, radix_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 last_reg, last_next;
    logic                 valid_reg, valid_next;

    logic [RADIX_W-1:0]   stack_mem [STACK_DEPTH];
    logic [RADIX_W-1:0]   rd_data_reg;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 push;

    logic [RADIX_W-1:0]   radix_in;
    logic [CHUNK_W-1:0]   chunk;
    logic [CHUNK_W-1:0]   qbits;
    logic [RADIX_W-1:0]   rem_out;
    logic [RADIX_W:0]     trial;
    logic [PAD_W-1:0]     quot;

    // Clamp of the incoming radix.
    always_comb begin
        radix_in = s_tdata[69:64];
        if (radix_in < RADIX_MIN) begin
            radix_in = RADIX_MIN;
        end else if (radix_in > RADIX_MAX) begin
            radix_in = RADIX_MAX;
        end
    end

    // Eight restoring long-division steps on the top chunk of the dividend.
    always_comb begin
        chunk   = work_reg[PAD_W-1 -: CHUNK_W];
        rem_out = rem_reg;
        qbits   = '0;
        trial   = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--) begin
            trial = {rem_out, chunk[i]};
            if (trial >= {1'b0, radix_reg}) begin
                qbits[i] = 1'b1;
                trial    = trial - {1'b0, radix_reg};
            end
            rem_out = trial[RADIX_W-1:0];
        end
        quot = (work_reg << CHUNK_W) | PAD_W'(qbits);
    end

    always_comb begin
        state_next = state_reg;
        work_next  = work_reg;
        rem_next   = rem_reg;
        radix_next = radix_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        valid_next = valid_reg;
        push       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    work_next  = PAD_W'(s_tdata[VALUE_WIDTH-1:0]);
                    radix_next = radix_in;
                    rem_next   = '0;
                    step_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                work_next = quot;
                if (step_reg == STEP_W'(STEPS - 1)) begin
                    push      = 1'b1;
                    rem_next  = '0;
                    step_next = '0;
                    cnt_next  = cnt_reg + 1'b1;
                    if (quot == '0 || cnt_reg == CNT_W'(STACK_DEPTH - 1)) begin
                        state_next = ST_RD;
                    end
                end else begin
                    rem_next  = rem_out;
                    step_next = step_reg + 1'b1;
                end
            end
            ST_RD: begin
                cnt_next   = cnt_reg - 1'b1;
                state_next = ST_LD;
            end
            ST_LD: begin
                char_next  = digit_to_ascii(rd_data_reg);
                last_next  = (cnt_reg == '0);
                valid_next = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    valid_next = 1'b0;
                    state_next = last_reg ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
        work_reg  <= work_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign rd_addr = ADDR_W'(cnt_reg - 1'b1);

    always_ff @(posedge aclk) begin
        if (push) begin
            stack_mem[cnt_reg[ADDR_W-1:0]] <= rem_out;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a digit is pending");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(STACK_DEPTH))
        else $error("digit count beyond stack depth");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("block not idle after final digit");

    a_last_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (cnt_reg == '0))
        else $error("final digit flagged with digits left on the stack");

endmodule

`default_nettype wire
